/* rtl/ogru_pkg.sv */
// ----------------------------------------------------------------------------
// ogru_pkg: shared types and constants for the occupancy grid ray update
// grid codes, sine table, defaults
// ----------------------------------------------------------------------------
package ogru_pkg;

   localparam int MapWidthDefault  = 64;
   localparam int MapHeightDefault = 64;

   localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
   localparam logic [1:0] CODE_FREE     = 2'd1;
   localparam logic [1:0] CODE_OBSTACLE = 2'd2;
   localparam logic [1:0] CODE_ROBOT    = 2'd3;

   localparam logic [1:0] REG_ROBOT_X   = 2'd0;
   localparam logic [1:0] REG_ROBOT_Y   = 2'd1;
   localparam logic [1:0] REG_MAX_RANGE = 2'd2;

   localparam logic [5:0]  ROBOT_X_RESET   = 6'd32;
   localparam logic [5:0]  ROBOT_Y_RESET   = 6'd32;
   localparam logic [15:0] MAX_RANGE_RESET = 16'd16384;

   // quarter wave, q0.15
   function automatic logic [14:0] quarter_sine(input logic [6:0] k);
      logic [14:0] v;
      case (k)
         7'd0: v = 15'd0;      7'd1: v = 15'd804;    7'd2: v = 15'd1608;
         7'd3: v = 15'd2411;   7'd4: v = 15'd3212;   7'd5: v = 15'd4011;
         7'd6: v = 15'd4808;   7'd7: v = 15'd5602;   7'd8: v = 15'd6393;
         7'd9: v = 15'd7180;   7'd10: v = 15'd7962;  7'd11: v = 15'd8740;
         7'd12: v = 15'd9512;  7'd13: v = 15'd10279; 7'd14: v = 15'd11039;
         7'd15: v = 15'd11793; 7'd16: v = 15'd12540; 7'd17: v = 15'd13279;
         7'd18: v = 15'd14010; 7'd19: v = 15'd14733; 7'd20: v = 15'd15447;
         7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17531;
         7'd24: v = 15'd18205; 7'd25: v = 15'd18868; 7'd26: v = 15'd19520;
         7'd27: v = 15'd20160; 7'd28: v = 15'd20788; 7'd29: v = 15'd21403;
         7'd30: v = 15'd22006; 7'd31: v = 15'd22595; 7'd32: v = 15'd23170;
         7'd33: v = 15'd23732; 7'd34: v = 15'd24279; 7'd35: v = 15'd24812;
         7'd36: v = 15'd25330; 7'd37: v = 15'd25833; 7'd38: v = 15'd26320;
         7'd39: v = 15'd26791; 7'd40: v = 15'd27246; 7'd41: v = 15'd27684;
         7'd42: v = 15'd28106; 7'd43: v = 15'd28511; 7'd44: v = 15'd28899;
         7'd45: v = 15'd29269; 7'd46: v = 15'd29622; 7'd47: v = 15'd29957;
         7'd48: v = 15'd30274; 7'd49: v = 15'd30572; 7'd50: v = 15'd30853;
         7'd51: v = 15'd31114; 7'd52: v = 15'd31357; 7'd53: v = 15'd31581;
         7'd54: v = 15'd31786; 7'd55: v = 15'd31972; 7'd56: v = 15'd32138;
         7'd57: v = 15'd32286; 7'd58: v = 15'd32413; 7'd59: v = 15'd32522;
         7'd60: v = 15'd32610; 7'd61: v = 15'd32679; 7'd62: v = 15'd32729;
         7'd63: v = 15'd32758; 7'd64: v = 15'd32767;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic        neg;
      logic [14:0] mag;
   } trig_type;

   function automatic trig_type sine_q15(input logic [7:0] idx);
      trig_type t;
      logic [6:0] k;
      k = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
      t.mag = quarter_sine(k);
      t.neg = idx[7] && (t.mag != 15'd0);
      return t;
   endfunction

   // grid access request from sequencer to grid store
   typedef struct packed {
      logic rd;
      logic wr;
      logic [1:0] wcode;
   } grid_ctl_type;

endpackage

/* rtl/occupancy_grid_ray_update.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update: range ray marking on a 2-bit occupancy grid
// ----------------------------------------------------------------------------
// req_ beats carry an operation: cast a ray (angle, distance) or read one
// cell (cell_x, cell_y). each beat gives one rsp_ beat: cell_code for a read,
// cells_written for a cast. csr_ writes set robot_x, robot_y and max_range;
// the user makes them only while the block is idle, the block does not enforce it.
// a read goes through S_RRD to S_RSP. a cast walks from the far end to
// the robot, ceil(distance/256) steps (at least one), each step using the
// shared offset multiplier once for x and once for y and the single grid
// port for a read then a write: a step runs S_MULX, S_MULY, S_CHK, S_RD
// and S_WR in turn, and a skipped cell goes from S_CHK straight to S_WR.
// one item is worked on at a time; req_stall is high until the response is
// taken. a stalled response holds.
// after reset the grid is cleared one cell a cycle, with req_stall high meanwhile.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update
   import ogru_pkg::*;
#(
   parameter int MAP_WIDTH  = MapWidthDefault,
   parameter int MAP_HEIGHT = MapHeightDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_angle,
   input  logic [15:0] req_distance,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_cell_code,
   output logic [8:0]  rsp_cells_written,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int XW = $clog2(MAP_WIDTH);
   localparam int YW = $clog2(MAP_HEIGHT);
   localparam int AW = XW + YW;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MULX = 8'b0000_0010,
      S_MULY = 8'b0000_0100,
      S_CHK  = 8'b0000_1000,
      S_RD   = 8'b0001_0000,
      S_WR   = 8'b0010_0000,
      S_RRD  = 8'b0100_0000,
      S_RSP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [5:0]  robot_x_ff, robot_y_ff;
   logic [15:0] max_range_ff;
   logic signed [17:0] d_ff, d_in;
   trig_type    sin_ff, cos_ff;
   logic        pend_ff, pend_in, have_ff, have_in;
   logic signed [11:0] lx_ff, lx_in, ly_ff, ly_in, cx_ff, cx_in;
   logic [8:0]  wr_ff, wr_in;
   logic [1:0]  code_ff, code_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic        rvalid_ff, rvalid_in;
   logic        direct_ff, direct_in;

   grid_ctl_type  ctl;
   logic [1:0]    rdata;
   logic          busy;
   logic signed [11:0] coord;
   logic [7:0]    idx;
   trig_type      mt;
   logic [5:0]    mbase;

   ogru_grid #(.AW(AW)) u_grid (
      .clock, .reset, .ctl, .addr(addr_ff), .rdata, .busy
   );

   assign mt    = (state_ff == S_MULX) ? cos_ff : sin_ff;
   assign mbase = (state_ff == S_MULX) ? robot_x_ff : robot_y_ff;

   ogru_offset u_offset (
      .clock, .d(d_ff[15:0]), .t(mt), .base(mbase), .coord
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         robot_x_ff   <= ROBOT_X_RESET;
         robot_y_ff   <= ROBOT_Y_RESET;
         max_range_ff <= MAX_RANGE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROBOT_X:   robot_x_ff   <= csr_data[5:0];
            REG_ROBOT_Y:   robot_y_ff   <= csr_data[5:0];
            REG_MAX_RANGE: max_range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE) || busy;
   assign idx = req_angle[15:8] + {7'd0, req_angle[7]};

   logic in_map, is_robot;
   logic signed [11:0] cy;
   assign cy = coord;
   assign in_map = (cx_ff >= 0) && (cx_ff < MAP_WIDTH) && (cy >= 0) && (cy < MAP_HEIGHT);
   assign is_robot = (cx_ff == $signed({6'd0, robot_x_ff}))
                  && (cy == $signed({6'd0, robot_y_ff}));

   always_comb begin
      state_in  = state_ff;
      d_in      = d_ff;
      pend_in   = pend_ff;
      have_in   = have_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      cx_in     = cx_ff;
      wr_in     = wr_ff;
      code_in   = code_ff;
      addr_in   = addr_ff;
      rvalid_in = rvalid_ff;
      direct_in = direct_ff;
      ctl       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !busy) begin
               wr_in   = '0;
               code_in = CODE_UNKNOWN;
               if (req_operation) begin
                  direct_in = 1'b1;
                  if (req_cell_x == robot_x_ff && req_cell_y == robot_y_ff) begin
                     code_in = CODE_ROBOT;
                  end else if (32'(req_cell_x) < MAP_WIDTH
                            && 32'(req_cell_y) < MAP_HEIGHT) begin
                     direct_in = 1'b0;
                     addr_in = AW'({req_cell_y, {XW{1'b0}}} | 32'(req_cell_x));
                  end
                  state_in = S_RRD;
               end else begin
                  d_in    = $signed({2'b00, req_distance});
                  pend_in = req_distance != max_range_ff;
                  have_in = 1'b0;
                  direct_in = 1'b1;
                  state_in = S_MULX;
               end
            end
         end
         S_MULX: state_in = S_MULY;
         S_MULY: begin
            cx_in = coord;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = S_WR;
            if (!have_ff || cx_ff != lx_ff || cy != ly_ff) begin
               have_in = 1'b1;
               lx_in = cx_ff;
               ly_in = cy;
               if (in_map && !is_robot) begin
                  addr_in = AW'(({20'd0, cy[YW-1:0]} << XW) | {20'd0, cx_ff[XW-1:0]});
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            ctl.rd = 1'b1;
            state_in = S_WR;
            direct_in = 1'b0;
         end
         S_WR: begin
            if (!direct_ff) begin
               direct_in = 1'b1;
               if (pend_ff) begin
                  ctl.wr = 1'b1;
                  ctl.wcode = CODE_OBSTACLE;
                  pend_in = 1'b0;
                  wr_in = wr_ff + 1'b1;
               end else if (rdata != CODE_OBSTACLE) begin
                  ctl.wr = 1'b1;
                  ctl.wcode = CODE_FREE;
                  wr_in = wr_ff + 1'b1;
               end
            end
            d_in = d_ff - 18'sd256;
            if (d_in > 0) state_in = S_MULX;
            else begin
               state_in = S_RSP;
               rvalid_in = 1'b1;
            end
         end
         S_RRD: begin
            ctl.rd = !direct_ff;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               if (!direct_ff) code_in = rdata;
            end else if (!rsp_stall) begin
               rvalid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      d_ff      <= d_in;
      pend_ff   <= pend_in;
      have_ff   <= have_in;
      lx_ff     <= lx_in;
      ly_ff     <= ly_in;
      cx_ff     <= cx_in;
      wr_ff     <= wr_in;
      code_ff   <= code_in;
      addr_ff   <= addr_in;
      direct_ff <= direct_in;
      if (state_ff == S_IDLE && req_valid && !busy) begin
         sin_ff <= sine_q15(idx);
         cos_ff <= sine_q15(idx + 8'd64);
      end
   end

   assign rsp_valid         = rvalid_ff;
   assign rsp_cell_code     = code_ff;
   assign rsp_cells_written = wr_ff;

endmodule

/* rtl/ogru_grid.sv */
// ----------------------------------------------------------------------------
// ogru_grid: occupancy grid store
// one read or write port, registered read, clearing pass after reset
// ----------------------------------------------------------------------------
module ogru_grid
   import ogru_pkg::*;
#(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  grid_ctl_type  ctl,
   input  logic [AW-1:0] addr,
   output logic [1:0]    rdata,
   output logic          busy
);

   localparam int Depth = 1 << AW;

   logic [1:0]    mem [Depth];
   logic [AW-1:0] clr_ff, clr_in;
   logic          busy_ff, busy_in;
   logic [1:0]    rdata_ff;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(Depth - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= CODE_UNKNOWN;
      end else if (ctl.wr) begin
         mem[addr] <= ctl.wcode;
      end
      if (ctl.rd) rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

/* rtl/ogru_offset.sv */
// ----------------------------------------------------------------------------
// ogru_offset: shared ray offset unit
// one 16x15 multiply per cycle, truncated toward zero, added to robot coordinate
// ----------------------------------------------------------------------------
module ogru_offset
   import ogru_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] d,
   input  trig_type    t,
   input  logic [5:0]  base,
   output logic signed [11:0] coord
);

   logic [30:0] prod_ff;
   logic        neg_ff;
   logic [5:0]  base_ff;
   logic [7:0]  q;

   always_ff @(posedge clock) begin
      prod_ff <= d * t.mag;
      neg_ff  <= t.neg;
      base_ff <= base;
   end

   assign q = prod_ff[30:23];
   assign coord = neg_ff ? $signed({6'd0, base_ff}) - $signed({4'd0, q})
                         : $signed({6'd0, base_ff}) + $signed({4'd0, q});

endmodule
